/* rtl/save_type_signature_scan_top_defines.svh */
// Assertion macros for the save-type signature scanner.
`ifndef SAVE_TYPE_SIGNATURE_SCAN_TOP_DEFINES_SVH
`define SAVE_TYPE_SIGNATURE_SCAN_TOP_DEFINES_SVH

// Checked while out of reset.
`define SWTS_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define SWTS_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/swts_pkg.sv */
// Package for the save-type signature scanner: kind codes, signatures, classifier.
package swts_pkg;

   localparam int TAIL_GUARD_DEF = 12;
   localparam int SIG_SPAN       = 10;
   localparam int KIND_W         = 3;

   localparam logic [KIND_W-1:0] KIND_NONE     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SRAM     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FLASH64  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FLASH128 = 3'd3;
   localparam logic [KIND_W-1:0] KIND_EEPROM   = 3'd4;

   localparam logic [9*8-1:0]  SIG_FLASH1M  = {"FLASH1M", "_V"};
   localparam logic [10*8-1:0] SIG_FLASH512 = {"FLASH512", "_V"};
   localparam logic [7*8-1:0]  SIG_FLASH    = "FLASH_V";
   localparam logic [6*8-1:0]  SIG_SRAM     = "SRAM_V";
   localparam logic [8*8-1:0]  SIG_EEPROM   = {"EEPROM", "_V"};

   // Oldest byte of the start position sits at the top index.
   typedef logic [SIG_SPAN-1:0][7:0] head_type;

   function automatic logic [KIND_W-1:0] classify(head_type head);
      logic [KIND_W-1:0] kind;
      kind = KIND_NONE;
      if (head[SIG_SPAN-1 -: 9] == SIG_FLASH1M) begin
         kind = KIND_FLASH128;
      end else if (head[SIG_SPAN-1 -: 10] == SIG_FLASH512 ||
                   head[SIG_SPAN-1 -: 7] == SIG_FLASH) begin
         kind = KIND_FLASH64;
      end else if (head[SIG_SPAN-1 -: 6] == SIG_SRAM) begin
         kind = KIND_SRAM;
      end else if (head[SIG_SPAN-1 -: 8] == SIG_EEPROM) begin
         kind = KIND_EEPROM;
      end
      return kind;
   endfunction

endpackage

/* rtl/save_type_signature_scan_top.sv */
// Save-type signature scanner, top level.
// Takes one image byte per cycle, back to back, and tests the start position
// TAIL_GUARD bytes behind the newest byte against the save signatures in the
// same cycle; the window is a shift register of TAIL_GUARD+1 bytes. A
// transaction marked last produces one result transaction (0 none, 1 SRAM,
// 2 flash 64K, 3 flash 128K, 4 EEPROM) on the following cycle from an output
// register, and the scan state is cleared for the next image. Input is taken
// whenever the output register is empty or being drained, so a held result
// stalls the input only for the cycles it is held.
module save_type_signature_scan_top
   import swts_pkg::*;
#(
   parameter int TAIL_GUARD = TAIL_GUARD_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_rom_byte,
   input  logic              req_is_last,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [KIND_W-1:0] rsp_save_kind
);

   localparam int WIN_LEN = TAIL_GUARD + 1;
   localparam int FILL_W  = $clog2(WIN_LEN + 1);

   logic [WIN_LEN-1:0][7:0] window_ff, window_in;
   logic [FILL_W-1:0]       fill_ff, fill_in, fill_step;
   logic                    found_ff, found_in;
   logic [KIND_W-1:0]       kind_ff, kind_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]       rsp_kind_ff, rsp_kind_in;

   logic                    accept;
   logic                    window_full;
   logic [KIND_W-1:0]       head_kind;
   logic [KIND_W-1:0]       kind_now;

   assign req_ready     = !rsp_valid_ff || rsp_ready;
   assign accept        = req_valid && req_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_save_kind = rsp_kind_ff;

   always_comb begin
      window_in   = {window_ff[WIN_LEN-2:0], req_rom_byte};
      fill_step   = (fill_ff == FILL_W'(WIN_LEN)) ? fill_ff : fill_ff + FILL_W'(1);
      window_full = (fill_step == FILL_W'(WIN_LEN));
      head_kind   = classify(window_in[WIN_LEN-1 -: SIG_SPAN]);
      if (found_ff) begin
         kind_now = kind_ff;
      end else if (window_full) begin
         kind_now = head_kind;
      end else begin
         kind_now = KIND_NONE;
      end

      fill_in      = fill_ff;
      found_in     = found_ff;
      kind_in      = kind_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         if (req_is_last) begin
            fill_in      = '0;
            found_in     = 1'b0;
            kind_in      = KIND_NONE;
            rsp_kind_in  = kind_now;
            rsp_valid_in = 1'b1;
         end else begin
            fill_in  = fill_step;
            found_in = (kind_now != KIND_NONE);
            kind_in  = kind_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         found_ff     <= 1'b0;
         kind_ff      <= KIND_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         found_ff     <= found_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff <= window_in;
      end
      rsp_kind_ff <= rsp_kind_in;
   end

endmodule

/* rtl/swts_check.sv */
// Port-level assertions for the save-type signature scanner, with bind.
`include "save_type_signature_scan_top_defines.svh"

module swts_check
   import swts_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_is_last,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [KIND_W-1:0] rsp_save_kind
);

   logic req_last_take;
   logic rsp_stall;

   assign req_last_take = req_valid && req_ready && req_is_last;
   assign rsp_stall     = rsp_valid && !rsp_ready;

   `SWTS_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_valid, "result valid after reset")
   `SWTS_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp_save_kind), "held result changed")
   `SWTS_ASSERT(a_kind_range, rsp_valid |-> rsp_save_kind <= KIND_EEPROM, "save kind out of range")
   `SWTS_ASSERT(a_rsp_only_after_last, !req_last_take && !rsp_stall |=> !rsp_valid, "stray result")
   `SWTS_ASSERT(a_stall_blocks_req, rsp_stall |-> !req_ready, "input taken while result stalled")

endmodule

bind save_type_signature_scan_top swts_check u_swts_check (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_is_last   (req_is_last),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_save_kind (rsp_save_kind)
);

/* verif/tb_save_type_signature_scan_top.sv */
// Save-type scanner testbench: directed and random images vs. table kinds or a scan predictor.
module tb_save_type_signature_scan_top
   import swts_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIN = TAIL_GUARD_DEF + 1;
   localparam int RANDOM_BYTES = 1050;
   localparam int CALM_BYTES = 900;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [7:0]        req_rom_byte = 8'h00;
   logic              req_is_last = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [KIND_W-1:0] rsp_save_kind;

   save_type_signature_scan_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_rom_byte  (req_rom_byte),
      .req_is_last   (req_is_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_save_kind (rsp_save_kind)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // scan predictor state
   logic [7:0]        scan_window [WIN];
   int                scan_fill;
   bit                scan_hit;
   logic [KIND_W-1:0] scan_kind;

   logic [KIND_W-1:0] kinds_due [$];
   logic [7:0]        image_bytes [$];
   int                errors = 0;
   int                random_sent = 0;
   bit                calm = 1'b0;

   string sig_text [5] = '{$sformatf("%s", SIG_FLASH1M), $sformatf("%s", SIG_FLASH512),
                           $sformatf("%s", SIG_FLASH), $sformatf("%s", SIG_SRAM),
                           $sformatf("%s", SIG_EEPROM)};

   typedef struct {
      string             text;
      int                pad_len;
      logic [7:0]        pad_byte;
      bit                typed;
      logic [KIND_W-1:0] kind;
   } image_row_type;

   // short images, each signature at the oldest position, tail positions, near misses
   image_row_type image_table [12] = '{
      '{"",                             1, 8'h00, 1'b1, KIND_NONE},
      '{"",                             1, 8'hFF, 1'b1, KIND_NONE},
      '{$sformatf("%s", SIG_FLASH1M),   3, 8'h00, 1'b1, KIND_NONE},
      '{$sformatf("%s", SIG_FLASH1M),   4, 8'hFF, 1'b1, KIND_FLASH128},
      '{$sformatf("%s", SIG_FLASH512),  3, 8'h00, 1'b1, KIND_FLASH64},
      '{"FLASH_V",                      6, 8'hFF, 1'b1, KIND_FLASH64},
      '{"SRAM_V",                       7, 8'h00, 1'b1, KIND_SRAM},
      '{$sformatf("%s", SIG_EEPROM),    5, 8'hFF, 1'b1, KIND_EEPROM},
      '{"ZSRAM_V",                      6, 8'h00, 1'b1, KIND_NONE},
      '{"SRAM_VFLASH_V",               12, 8'hFF, 1'b0, KIND_NONE},
      '{"FLASH1M_X",                    4, 8'h00, 1'b0, KIND_NONE},
      '{$sformatf("X%s", SIG_EEPROM),   4, 8'hFF, 1'b0, KIND_NONE}
   };

   function automatic bit head_is(string sig);
      for (int k = 0; k < sig.len(); k++) begin
         if (scan_window[k] != sig[k]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void scan_clear();
      for (int k = 0; k < WIN; k++) scan_window[k] = 8'h00;
      scan_fill = 0;
      scan_hit  = 1'b0;
      scan_kind = KIND_NONE;
   endfunction

   // shift one byte in, test the oldest start position; returns the kind held so far
   function automatic logic [KIND_W-1:0] scan_byte(logic [7:0] b, bit last);
      logic [KIND_W-1:0] hit_kind;
      logic [KIND_W-1:0] held;
      hit_kind = KIND_NONE;
      for (int k = 0; k < WIN - 1; k++) scan_window[k] = scan_window[k + 1];
      scan_window[WIN - 1] = b;
      if (scan_fill < WIN) scan_fill++;
      if (scan_fill == WIN && !scan_hit) begin
         if (head_is(sig_text[0])) begin
            hit_kind = KIND_FLASH128;
         end else if (head_is(sig_text[1]) || head_is(sig_text[2])) begin
            hit_kind = KIND_FLASH64;
         end else if (head_is(sig_text[3])) begin
            hit_kind = KIND_SRAM;
         end else if (head_is(sig_text[4])) begin
            hit_kind = KIND_EEPROM;
         end
         if (hit_kind != KIND_NONE) begin
            scan_hit  = 1'b1;
            scan_kind = hit_kind;
         end
      end
      held = scan_kind;
      if (last) scan_clear();
      return held;
   endfunction

   task automatic send_image(bit typed, logic [KIND_W-1:0] typed_kind, bit counted);
      logic [KIND_W-1:0] kind;
      bit                last;
      for (int i = 0; i < image_bytes.size(); i++) begin
         last = (i == image_bytes.size() - 1);
         req_valid    <= 1'b1;
         req_rom_byte <= image_bytes[i];
         req_is_last  <= last;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         kind = scan_byte(image_bytes[i], last);
         if (last) kinds_due.push_back(typed ? typed_kind : kind);
         if (counted) begin
            random_sent++;
            if (random_sent >= CALM_BYTES) calm = 1'b1;
         end
         if (!calm && $urandom_range(0, 5) == 0) begin
            req_valid    <= 1'b0;
            req_rom_byte <= 8'($urandom);
            req_is_last  <= 1'($urandom);
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
      end
   endtask

   always @(posedge clock) begin : check_kind
      logic [KIND_W-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (kinds_due.size() == 0) begin
            $error("save_kind: unexpected transaction, actual %0d", rsp_save_kind);
            errors++;
         end else begin
            want = kinds_due.pop_front();
            if (rsp_save_kind !== want) begin
               $error("save_kind: expected %0d, actual %0d", want, rsp_save_kind);
               errors++;
            end
         end
      end
   end

   initial begin : drain
      forever begin
         @(posedge clock);
         rsp_ready <= 1'b1;
         repeat ($urandom_range(0, 20)) @(posedge clock);
         if (!calm && $urandom_range(0, 1) == 1) begin
            @(posedge clock);
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 10)) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      #4_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      int    len;
      int    pos;
      int    sig;
      int    roll;
      string noise_chars;
      noise_chars = "FLASH1M512_VSREOP";
      scan_clear();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (image_table[r]) begin
         image_bytes.delete();
         for (int k = 0; k < image_table[r].text.len(); k++)
            image_bytes.push_back(image_table[r].text[k]);
         repeat (image_table[r].pad_len) image_bytes.push_back(image_table[r].pad_byte);
         send_image(image_table[r].typed, image_table[r].kind, 1'b0);
      end

      while (random_sent < RANDOM_BYTES) begin
         roll = $urandom_range(0, 99);
         if (roll < 15) len = $urandom_range(1, TAIL_GUARD_DEF);
         else if (roll < 20) len = $urandom_range(60, 120);
         else len = $urandom_range(WIN, 40);
         image_bytes.delete();
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 1) == 1)
               image_bytes.push_back(noise_chars[$urandom_range(0, noise_chars.len() - 1)]);
            else
               image_bytes.push_back(8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 4) != 0) begin
            repeat ($urandom_range(1, 3)) begin
               sig = $urandom_range(0, 4);
               pos = $urandom_range(0, len - 1);
               for (int k = 0; k < sig_text[sig].len() && pos + k < len; k++)
                  image_bytes[pos + k] = sig_text[sig][k];
               if ($urandom_range(0, 3) == 0)
                  image_bytes[pos] = image_bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
            end
         end
         send_image(1'b0, KIND_NONE, 1'b1);
      end
      req_valid <= 1'b0;

      while (kinds_due.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
